// ===== rtl/cae_pkg.sv =====
// ----------------------------------------------------------------------------
// cae_pkg
// Shared types and constants for the column aggregate engine.
// ----------------------------------------------------------------------------
package cae_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned SUM_WIDTH   = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 3;

  // aggregate codes
  localparam logic [2:0] AGG_COUNT = 3'd0;
  localparam logic [2:0] AGG_SUM   = 3'd1;
  localparam logic [2:0] AGG_AVG   = 3'd2;
  localparam logic [2:0] AGG_MAX   = 3'd3;
  localparam logic [2:0] AGG_MIN   = 3'd4;

  // column kind codes
  localparam logic [1:0] KIND_STAR  = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AGG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_KIND = 2'd1;

  // one classified word in the queue
  typedef struct packed {
    logic                          is_end;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          present;
  } item_t;

  typedef struct packed {
    logic [2:0] agg_mode;
    logic [1:0] column_kind;
  } cfg_t;

  // request from the back end to the divider
  typedef struct packed {
    logic                   start;
    logic                   ack;
    logic                   neg;
    logic [SUM_WIDTH-1:0]   magnitude;
    logic [COUNT_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [SUM_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/column_aggregate_engine.sv =====
// ----------------------------------------------------------------------------
// column_aggregate_engine
// COUNT / SUM / AVG / MAX / MIN over a stream of signed fixed-point values.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    cmd_i, value_i, field_present_i
// out       output     out_valid_o / out_ready_i  result_o, result_valid_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Row words are taken one per cycle through a two-entry queue, except while a
// divide runs or a held end word heads it, and are folded into the accumulators.
// An end word registers its result directly; AVG runs the restoring divider.
// Reset clears all control state and the accumulators at once.
// A full output register holds back end words, and the rows queued behind them.
// ----------------------------------------------------------------------------
module column_aggregate_engine import cae_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic signed [31:0]    value_i,
  input  logic                  field_present_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [63:0]    result_o,
  output logic                  result_valid_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  logic     q_valid, q_pop;
  item_t    q_item;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [SUM_WIDTH-1:0] result;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.agg_mode    <= AGG_COUNT;
      cfg_q.column_kind <= KIND_STAR;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_AGG_MODE:    cfg_q.agg_mode    <= cfg_data_i[2:0];
        REG_COLUMN_KIND: cfg_q.column_kind <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  cae_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .value_i         (value_i),
    .field_present_i (field_present_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  cae_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result),
    .result_valid_o (result_valid_o)
  );

  cae_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign result_o = result;

endmodule

// ===== rtl/cae_front.sv =====
// ----------------------------------------------------------------------------
// cae_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cae_front import cae_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic signed [31:0]     value_i,
  input  logic                   field_present_i,
  output logic                   q_valid_o,
  output item_t                  q_item_o,
  input  logic                   q_pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  logic        push;
  item_t       item_in;

  // classify the incoming word
  always_comb begin
    item_in.is_end  = cmd_i;
    item_in.value   = value_i[VALUE_WIDTH-1:0];
    item_in.present = field_present_i;
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push)    wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== rtl/cae_div.sv =====
// ----------------------------------------------------------------------------
// cae_div
// Restoring divider, one quotient bit per cycle, sign applied at the end.
// ----------------------------------------------------------------------------
module cae_div import cae_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned STEP_W = $clog2(SUM_WIDTH);

  logic [SUM_WIDTH-1:0]   dvd_q, dvd_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [COUNT_WIDTH-1:0] dsr_q;
  logic                   neg_q;
  logic                   busy_q, done_q;
  logic [STEP_W-1:0]      step_q;
  logic [COUNT_WIDTH:0]   shifted;
  logic [COUNT_WIDTH:0]   diff;
  logic                   ge;

  // one restoring step; the remainder stays below the divisor, so the
  // top bit of the difference is its borrow
  always_comb begin
    shifted = {rem_q, dvd_q[SUM_WIDTH-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = !diff[COUNT_WIDTH];
    rem_d   = ge ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
    dvd_d   = {dvd_q[SUM_WIDTH-2:0], ge};
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~dvd_q + 1'b1) : dvd_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.magnitude;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(SUM_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.ack) begin
        done_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/cae_back.sv =====
// ----------------------------------------------------------------------------
// cae_back
// Accumulates row words and forms the aggregate on an end word.
// ----------------------------------------------------------------------------
module cae_back import cae_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  output div_req_t             div_req_o,
  input  div_rsp_t             div_rsp_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SUM_WIDTH-1:0] result_o,
  output logic                 result_valid_o
);

  typedef enum logic {ST_RUN, ST_DIV} state_e;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] S_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] S_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  state_e                        state_q;
  logic [COUNT_WIDTH-1:0]        rows_q, pres_q;
  logic signed [SUM_WIDTH-1:0]   sum_q, sum_d;
  logic signed [VALUE_WIDTH-1:0] max_q, min_q;
  logic                          out_valid_q, res_valid_q;
  logic [SUM_WIDTH-1:0]          result_q;

  logic                          out_free, found, out_load;
  logic signed [SUM_WIDTH-1:0]   vext, raw_sum;
  logic                          end_valid, end_avg;
  logic [SUM_WIDTH-1:0]          end_res;

  assign out_free = !out_valid_q || out_ready_i;
  assign found    = (cfg_i.column_kind == KIND_FOUND);
  assign q_pop_o  = (state_q == ST_RUN) && q_valid_i && (!q_item_i.is_end || out_free);

  // saturating running sum
  always_comb begin
    vext    = {{(SUM_WIDTH-VALUE_WIDTH){q_item_i.value[VALUE_WIDTH-1]}}, q_item_i.value};
    raw_sum = sum_q + vext;
    if (sum_q[SUM_WIDTH-1] == vext[SUM_WIDTH-1] &&
        raw_sum[SUM_WIDTH-1] != sum_q[SUM_WIDTH-1]) begin
      sum_d = sum_q[SUM_WIDTH-1] ? S_MIN : S_MAX;
    end else begin
      sum_d = raw_sum;
    end
  end

  // aggregate on end word
  always_comb begin
    end_valid = 1'b0;
    end_avg   = 1'b0;
    end_res   = '0;
    unique case (cfg_i.agg_mode)
      AGG_COUNT: begin
        end_valid = 1'b1;
        if (cfg_i.column_kind == KIND_STAR) begin
          end_res = {{(SUM_WIDTH-COUNT_WIDTH){1'b0}}, rows_q};
        end else if (found) begin
          end_res = {{(SUM_WIDTH-COUNT_WIDTH){1'b0}}, pres_q};
        end
      end
      AGG_SUM: begin
        end_valid = found;
        end_res   = found ? sum_q : '0;
      end
      AGG_AVG: begin
        end_avg = found && (rows_q != '0);
      end
      AGG_MAX: begin
        end_valid = found && (rows_q != '0);
        end_res   = end_valid ? {{(SUM_WIDTH-VALUE_WIDTH){max_q[VALUE_WIDTH-1]}}, max_q} : '0;
      end
      AGG_MIN: begin
        end_valid = found && (rows_q != '0);
        end_res   = end_valid ? {{(SUM_WIDTH-VALUE_WIDTH){min_q[VALUE_WIDTH-1]}}, min_q} : '0;
      end
      default: begin
        end_valid = 1'b0;
      end
    endcase
  end

  // divider request
  always_comb begin
    div_req_o.start     = q_pop_o && q_item_i.is_end && end_avg;
    div_req_o.ack       = (state_q == ST_DIV) && div_rsp_i.done && out_free;
    div_req_o.neg       = sum_q[SUM_WIDTH-1];
    div_req_o.magnitude = sum_q[SUM_WIDTH-1] ? (~sum_q + 1'b1) : sum_q;
    div_req_o.divisor   = rows_q;
  end

  // a result word enters the output register this cycle
  assign out_load = ((state_q == ST_RUN) && q_pop_o && q_item_i.is_end && !end_avg) ||
                    div_req_o.ack;

  assign out_valid_o    = out_valid_q;
  assign result_o       = result_q;
  assign result_valid_o = res_valid_q;

  // state, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      rows_q      <= '0;
      pres_q      <= '0;
      sum_q       <= '0;
      max_q       <= V_MIN;
      min_q       <= V_MAX;
      out_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          if (q_pop_o && !q_item_i.is_end) begin
            if (rows_q != CNT_MAX) rows_q <= rows_q + 1'b1;
            if (q_item_i.present && pres_q != CNT_MAX) pres_q <= pres_q + 1'b1;
            sum_q <= sum_d;
            if (q_item_i.value > max_q) max_q <= q_item_i.value;
            if (q_item_i.value < min_q) min_q <= q_item_i.value;
          end else if (q_pop_o) begin
            if (end_avg) begin
              state_q <= ST_DIV;
            end else begin
              result_q    <= end_res;
              res_valid_q <= end_valid;
            end
            rows_q <= '0;
            pres_q <= '0;
            sum_q  <= '0;
            max_q  <= V_MIN;
            min_q  <= V_MAX;
          end
        end
        ST_DIV: begin
          if (div_req_o.ack) begin
            result_q    <= div_rsp_i.quotient;
            res_valid_q <= 1'b1;
            state_q     <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

endmodule

// ===== test/tb_column_aggregate_engine.sv =====
// ----------------------------------------------------------------------------
// tb_column_aggregate_engine
// Self-checking bench for the COUNT / SUM / AVG / MAX / MIN column engine.
// A short stimulus table covers the corner cases first. Random phases with
// random register settings follow. Every accepted input word updates a
// running model of the aggregates. Every end word queues the aggregate that
// the model predicts, and the output monitor compares each result word with
// the oldest prediction. Both sides insert random idle cycles. Once, the
// receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_column_aggregate_engine;
  import cae_pkg::*;

  // column kinds, aggregate codes and register indexes not named in the package
  localparam logic [1:0] KIND_MISSING = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;
  localparam logic [2:0] AGG_SPARE_LO = 3'd5;
  localparam logic [2:0] AGG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic signed [31:0] VAL_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_BOTTOM = 32'sh8000_0000;
  localparam logic signed [63:0] SUM_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_BOTTOM = 64'sh8000_0000_0000_0000;

  localparam int SETTLE_CYCLES = 100;    // longer than one divide
  localparam int HOLD_CYCLES   = 300;    // long receiver stall
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_WORDS  = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  cmd_i;
  logic signed [31:0]    value_i;
  logic                  field_present_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic signed [63:0]    result_o;
  logic                  result_valid_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  column_aggregate_engine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .value_i         (value_i),
    .field_present_i (field_present_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_o        (result_o),
    .result_valid_o  (result_valid_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock, period 20
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one aggregate as the output side should show it
  typedef struct {
    logic signed [63:0] value;
    logic               exists;
  } aggregate_t;

  typedef enum logic [1:0] {W_ROW, W_END, W_CFG} plan_kind_e;

  // one row of the directed stimulus table
  typedef struct {
    plan_kind_e           kind;
    logic signed [31:0]   value;
    logic                 present;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic                 typed;
    logic signed [63:0]   exp_value;
    logic                 exp_exists;
  } plan_step_t;

  plan_step_t plan_q[$];
  aggregate_t pending_aggs[$];

  // running model of the block
  logic [2:0]         cur_mode;
  logic [1:0]         cur_kind;
  logic [31:0]        rows_seen;
  logic [31:0]        present_seen;
  logic signed [63:0] sum_acc;
  logic signed [31:0] peak_hi;
  logic signed [31:0] peak_lo;

  int  err_count;
  int  words_sent;
  int  aggs_checked;
  int  reg_writes;
  bit  calm;
  bit  hold_req;

  // ---------------------------------------------------------------- model

  function automatic void clear_accumulators();
    rows_seen    = '0;
    present_seen = '0;
    sum_acc      = '0;
    peak_hi      = VAL_BOTTOM;
    peak_lo      = VAL_TOP;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_AGG_MODE) cur_mode = data;
    else if (idx == REG_COLUMN_KIND) cur_kind = data[1:0];
  endfunction

  // fold one row into the accumulators, counts and sum saturate
  function automatic void fold_row(input logic signed [31:0] v, input logic p);
    logic signed [64:0] wide;
    if (rows_seen != '1) rows_seen = rows_seen + 1;
    if (p && present_seen != '1) present_seen = present_seen + 1;
    wide = {sum_acc[63], sum_acc} + {{33{v[31]}}, v};
    if (wide[64] != wide[63]) sum_acc = wide[64] ? SUM_BOTTOM : SUM_TOP;
    else sum_acc = wide[63:0];
    if (v > peak_hi) peak_hi = v;
    if (v < peak_lo) peak_lo = v;
  endfunction

  // aggregate for an end word, then back to the cleared state
  function automatic aggregate_t close_set();
    aggregate_t r;
    logic       found;
    found = (cur_kind == KIND_FOUND);
    r.value  = '0;
    r.exists = 1'b0;
    case (cur_mode)
      AGG_COUNT: begin
        r.exists = 1'b1;
        if (cur_kind == KIND_STAR) r.value = {32'd0, rows_seen};
        else if (found) r.value = {32'd0, present_seen};
      end
      AGG_SUM: begin
        if (found) begin
          r.exists = 1'b1;
          r.value  = sum_acc;
        end
      end
      AGG_AVG: begin
        if (found && rows_seen != 0) begin
          r.exists = 1'b1;
          r.value  = sum_acc / $signed({32'd0, rows_seen});
        end
      end
      AGG_MAX: begin
        if (found && rows_seen != 0) begin
          r.exists = 1'b1;
          r.value  = {{32{peak_hi[31]}}, peak_hi};
        end
      end
      AGG_MIN: begin
        if (found && rows_seen != 0) begin
          r.exists = 1'b1;
          r.value  = {{32{peak_lo[31]}}, peak_lo};
        end
      end
      default: ;
    endcase
    clear_accumulators();
    return r;
  endfunction

  // ------------------------------------------------------------ reporting

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------- drive

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_TOP;
      1:       return VAL_BOTTOM;
      2:       return '0;
      3:       return $signed(32'($urandom_range(0, 20))) - 32'sd10;
      4:       return ($signed(32'($urandom_range(0, 200))) - 32'sd100) <<< 16;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // offer one word after a random gap; valid is only lowered for a gap
  task automatic send_word(input logic is_end, input logic signed [31:0] v,
                           input logic p, input logic typed,
                           input logic signed [63:0] t_value, input logic t_exists);
    int         gap;
    aggregate_t r;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= is_end;
    value_i         <= v;
    field_present_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (!is_end) begin
      fold_row(v, p);
    end else begin
      r = close_set();
      if (typed) begin
        r.value  = t_value;
        r.exists = t_exists;
      end
      pending_aggs.insert(pending_aggs.size(), r);
    end
  endtask

  task automatic send_random_word(input logic is_end);
    send_word(is_end, rand_value(), 1'($urandom), 1'b0, '0, 1'b0);
  endtask

  // stop offering and wait for every outstanding aggregate, then let it settle
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_aggs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write; valid stays up when another write follows directly
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input logic last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    reg_writes++;
    if (last) cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------- table helpers

  function automatic void plan_row(input logic signed [31:0] v, input logic p);
    plan_q.insert(plan_q.size(), '{W_ROW, v, p, '0, '0, 1'b0, '0, 1'b0});
  endfunction

  function automatic void plan_end();
    plan_q.insert(plan_q.size(), '{W_END, '0, 1'b0, '0, '0, 1'b0, '0, 1'b0});
  endfunction

  function automatic void plan_end_typed(input logic signed [63:0] v, input logic e);
    plan_q.insert(plan_q.size(), '{W_END, VAL_TOP, 1'b1, '0, '0, 1'b1, v, e});
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    plan_q.insert(plan_q.size(), '{W_CFG, '0, 1'b0, idx, data, 1'b0, '0, 1'b0});
  endfunction

  // ------------------------------------------------------------- receiver

  // per-result random stall, or one long hold when asked for
  initial begin : out_side
    int         gap;
    aggregate_t want;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_aggs.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: result %0d valid %0b",
                                  result_o, result_valid_o));
      end else begin
        want = pending_aggs.pop_front();
        aggs_checked++;
        if (result_o !== want.value)
          report_mismatch($sformatf("result: got %0d, expected %0d", result_o, want.value));
        if (result_valid_o !== want.exists)
          report_mismatch($sformatf("result_valid: got %0b, expected %0b",
                                    result_valid_o, want.exists));
      end
    end
  end

  // --------------------------------------------------------------- limit

  initial begin : watchdog
    #(200000 * 20);
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------- stimulus

  initial begin : stimulus
    int          phase;
    int          n_sets;
    int          n_rows;
    int          waited;
    logic [2:0]  mode_pick;
    logic [1:0]  kind_pick;
    plan_step_t  st;

    err_count    = 0;
    words_sent   = 0;
    aggs_checked = 0;
    reg_writes   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    cur_mode     = AGG_COUNT;
    cur_kind     = KIND_STAR;
    clear_accumulators();

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    cmd_i           <= 1'b0;
    value_i         <= '0;
    field_present_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset values, extremes, every mode, empty sets
    plan_end_typed(64'sd0, 1'b1);                 // star count, no rows
    plan_cfg(REG_AGG_MODE, AGG_SUM);
    plan_cfg(REG_COLUMN_KIND, {1'b0, KIND_FOUND});
    plan_end_typed(64'sd0, 1'b1);                 // sum over no rows
    plan_row(VAL_TOP, 1'b1);
    plan_row(VAL_BOTTOM, 1'b0);
    plan_row(VAL_TOP, 1'b1);
    plan_end();
    plan_cfg(REG_AGG_MODE, AGG_AVG);
    plan_end_typed(64'sd0, 1'b0);                 // average over no rows
    plan_row(-32'sd5, 1'b1);
    plan_row(-32'sd2, 1'b1);
    plan_end();                                   // rounds toward zero
    plan_cfg(REG_AGG_MODE, AGG_MAX);
    plan_row(VAL_BOTTOM, 1'b1);
    plan_end();
    plan_end_typed(64'sd0, 1'b0);                 // max over no rows
    plan_cfg(REG_AGG_MODE, AGG_MIN);
    plan_row(VAL_TOP, 1'b0);
    plan_row(32'sd5, 1'b1);
    plan_end();
    plan_end_typed(64'sd0, 1'b0);                 // min over no rows
    plan_cfg(REG_SPARE_LO, 3'd7);                 // spare indexes are ignored
    plan_cfg(REG_SPARE_HI, 3'd2);
    plan_cfg(REG_COLUMN_KIND, {1'b0, KIND_MISSING});
    plan_row(32'sd1, 1'b1);
    plan_end_typed(64'sd0, 1'b0);                 // min, column missing
    plan_cfg(REG_AGG_MODE, AGG_COUNT);
    plan_row(32'sd1, 1'b1);
    plan_end_typed(64'sd0, 1'b1);                 // count, column missing
    plan_cfg(REG_COLUMN_KIND, {1'b1, KIND_SPARE});
    plan_end_typed(64'sd0, 1'b1);                 // spare kind acts as missing
    plan_cfg(REG_COLUMN_KIND, {1'b0, KIND_FOUND});
    plan_row(32'sd7, 1'b1);
    plan_row(32'sd8, 1'b0);
    plan_row(32'sd9, 1'b1);
    plan_end_typed(64'sd2, 1'b1);                 // count of present fields
    plan_cfg(REG_AGG_MODE, AGG_SPARE_LO);
    plan_row(32'sd3, 1'b1);
    plan_end_typed(64'sd0, 1'b0);
    plan_cfg(REG_AGG_MODE, AGG_SPARE_HI);
    plan_end_typed(64'sd0, 1'b0);

    foreach (plan_q[i]) begin
      st = plan_q[i];
      case (st.kind)
        W_ROW: send_word(1'b0, st.value, st.present, 1'b0, '0, 1'b0);
        W_END: send_word(1'b1, st.value, st.present, st.typed, st.exp_value,
                         st.exp_exists);
        default: begin
          wait_drain();
          write_reg(st.idx, st.data, 1'b1);
        end
      endcase
    end

    // random phases, each with its own register setting
    phase = 0;
    while (words_sent < RANDOM_WORDS + plan_q.size()) begin
      wait_drain();
      mode_pick = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 4))
                                              : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0:       kind_pick = KIND_STAR;
        1:       kind_pick = KIND_MISSING;
        2:       kind_pick = KIND_SPARE;
        default: kind_pick = KIND_FOUND;
      endcase
      write_reg(REG_AGG_MODE, mode_pick, 1'b0);
      write_reg(REG_COLUMN_KIND, {1'($urandom), kind_pick}, 1'b1);
      calm = ($urandom_range(0, 4) == 0);

      if (phase == 6) begin
        // long receiver hold while short sets keep arriving at full rate
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (20) begin
          repeat ($urandom_range(0, 2)) send_random_word(1'b0);
          send_random_word(1'b1);
        end
      end else begin
        n_sets = $urandom_range(1, 5);
        repeat (n_sets) begin
          n_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                               : $urandom_range(0, 6);
          repeat (n_rows) send_random_word(1'b0);
          send_random_word(1'b1);
          // in one phase, hold the sender back after each set until every result is home
          if (phase == 3) begin
            in_valid_i <= 1'b0;
            while (pending_aggs.size() != 0) @(posedge clk_i);
          end
        end
      end
      phase++;
    end

    // drain and settle
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_aggs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_aggs.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_aggs.size()));

    $display("Sent %0d words over %0d random phases, %0d register writes.",
             words_sent, phase, reg_writes);
    $display("Checked %0d aggregates across all modes and column kinds.", aggs_checked);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
